// ----- src/nbsdof_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and saturating helpers for the Newmark-beta oscillator block.
package nbsdof_pkg;

	localparam int STATE_WIDTH  = 48;
	localparam int FRAC_BITS    = 24;
	localparam int SAMPLE_WIDTH = 32;

	typedef logic signed [STATE_WIDTH-1:0] word_t;

	localparam word_t WMAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
	localparam word_t WMIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};
	localparam word_t ONE_Q = word_t'(48'd1 << FRAC_BITS);
	localparam word_t HALF_Q = word_t'(48'd1 << (FRAC_BITS - 1));

	// 4*pi^2 in Q32 times 1e6 (ms^2 to s^2), and 4*pi in Q32 times 1000.
	localparam logic [63:0] OMEGA_NUM = 64'd169558512509000000;
	localparam logic [47:0] DAMP_NUM  = 48'd53972150818000;

	// dt = step*2^24/1000 split into an integer part and a remainder fixed by reciprocal.
	localparam int DT_INT   = 16777;
	localparam int DT_REM   = 216;
	localparam int DT_RND   = 500;
	localparam int DT_RECIP = 268436;
	localparam int HF_INT   = 8388;
	localparam int HF_REM   = 1216;
	localparam int HF_RND   = 1000;
	localparam int HF_RECIP = 1073742;

	localparam int MUL_PARTS = 4;
	localparam int DIV_STEPS = 65;

	typedef enum logic [2:0] {
		CFG_PERIOD, CFG_STEP, CFG_DAMP, CFG_BETA,
		CFG_DISP, CFG_VEL, CFG_ACC, CFG_GROUND
	} cfg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE, S_PREP, S_DT2, S_KHB, S_KB,
		S_PSQ, S_WDIV, S_HC, S_DDIV, S_DEN1, S_DEN2, S_RDIV, S_LOAD,
		S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_FIN
	} state_t;

	function automatic word_t sat_add(word_t a, word_t b);
		logic signed [STATE_WIDTH:0] s;
		s = {a[STATE_WIDTH-1], a} + {b[STATE_WIDTH-1], b};
		if (s[STATE_WIDTH] != s[STATE_WIDTH-1]) begin
			return s[STATE_WIDTH] ? WMIN : WMAX;
		end
		return s[STATE_WIDTH-1:0];
	endfunction

	function automatic word_t sat_sub(word_t a, word_t b);
		logic signed [STATE_WIDTH:0] s;
		s = {a[STATE_WIDTH-1], a} - {b[STATE_WIDTH-1], b};
		if (s[STATE_WIDTH] != s[STATE_WIDTH-1]) begin
			return s[STATE_WIDTH] ? WMIN : WMAX;
		end
		return s[STATE_WIDTH-1:0];
	endfunction

endpackage

// ----- src/nbsdof_mul.sv -----
`timescale 1ns / 1ps
// Shared multiplier: four 24x24 partial products, then rounding and saturation.
module nbsdof_mul import nbsdof_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  word_t        a,
	input  word_t        b,
	output logic         done,
	output word_t        q,
	output logic [95:0]  prod
);

	logic [47:0] am_q, bm_q;
	logic        neg_q;
	logic [2:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [95:0] acc_q;
	word_t       q_q;

	logic [23:0] pa, pb;
	logic [47:0] pp;
	logic [95:0] pp_sh;
	logic [95:0] rsum;
	logic [71:0] qv;
	logic [71:0] lim;

	always_comb begin
		pa = cnt_q[1] ? am_q[47:24] : am_q[23:0];
		pb = cnt_q[0] ? bm_q[47:24] : bm_q[23:0];
		pp = 48'(pa) * 48'(pb);
		case (cnt_q)
			3'd0: pp_sh = {48'd0, pp};
			3'd3: pp_sh = {pp, 48'd0};
			default: pp_sh = {24'd0, pp, 24'd0};
		endcase
		rsum = acc_q + 96'(HALF_Q);
		qv = rsum[95:FRAC_BITS];
		lim = 72'(WMAX) + 72'(neg_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == 3'(MUL_PARTS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			am_q <= a[47] ? 48'(-a) : 48'(a);
			bm_q <= b[47] ? 48'(-b) : 48'(b);
			neg_q <= a[47] ^ b[47];
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == 3'(MUL_PARTS)) begin
				if (qv > lim) begin
					q_q <= neg_q ? WMIN : WMAX;
				end else begin
					q_q <= neg_q ? word_t'(-qv[47:0]) : word_t'(qv[47:0]);
				end
			end else begin
				acc_q <= acc_q + pp_sh;
			end
		end
	end

	assign done = done_q;
	assign q = q_q;
	assign prod = acc_q;

endmodule

// ----- src/nbsdof_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, quotient capped at the word maximum.
module nbsdof_div import nbsdof_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [64:0] num,
	input  logic [47:0] den,
	output logic        done,
	output word_t       q
);

	logic [64:0] n_q;
	logic [47:0] d_q;
	logic [47:0] r_q;
	logic [64:0] quo_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [48:0] rs;
	logic        ge;
	logic [48:0] rn;

	always_comb begin
		rs = {r_q, n_q[64]};
		ge = rs >= {1'b0, d_q};
		rn = ge ? rs - {1'b0, d_q} : rs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[63:0], 1'b0};
			r_q <= rn[47:0];
			quo_q <= {quo_q[63:0], ge};
		end
	end

	assign done = done_q;
	assign q = (quo_q > 65'(WMAX)) ? WMAX : word_t'(quo_q[47:0]);

endmodule

// ----- src/newmark_beta_sdof_response_top.sv -----
`timescale 1ns / 1ps
// Newmark-beta single-mass oscillator: sequencer, state and channel registers.
// Input channel: a request carries ground_acc and record_start, taken when in_valid is
// high and in_stall is low. in_stall is high while an item is being worked on.
// Output channel: one request per result (displacement, velocity, relative and absolute
// acceleration, running peak), last_of_run marks the final result of an item.
// Configuration writes (cfg_we, cfg_index, cfg_data) belong between items: the user
// must keep to that, the block does not enforce it. The sequencer's products and
// quotients run through one shared 48-bit multiplier (four 24x24 partial products)
// and one bit-serial divider. A plain item needs eleven products; the next request is
// taken only once the sequencer is back in idle after the result.
// With record_start the coefficients are rebuilt first (up to four more products and
// up to three divisions) and two results are produced.
// The result register frees the input side: a new item is taken while a result waits.
// If the receiver stalls, the finished result is held and the next one waits behind it.
// Reset restores the register defaults, clears state and peak, omega, damp and recip.
module newmark_beta_sdof_response_top import nbsdof_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  ground_acc,
	input  logic                record_start,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [47:0]  displacement,
	output logic signed [47:0]  velocity,
	output logic signed [47:0]  relative_acc,
	output logic signed [31:0]  absolute_acc,
	output logic [30:0]         peak_abs_acc,
	output logic                last_of_run
);

	logic [15:0]        period_q, ratio_q, beta_q;
	logic [9:0]         step_q;
	logic signed [31:0] sdisp_q, svel_q, sacc_q, sground_q;

	logic [17:0] dty_s1;
	logic [24:0] dtb_s1;
	logic [20:0] hfy_s1;
	logic [23:0] hfb_s1;
	logic [36:0] dtp;
	logic [41:0] hfp;
	word_t       dt_q, half_q;

	state_t state_q, state_d;
	logic   issued_q;
	logic   is_mul, is_div;
	logic   mul_start, div_start;
	logic   mul_done, div_done;
	word_t  mul_a, mul_b, mul_q, div_q;
	logic [95:0] mul_prod;
	logic [64:0] div_num;
	logic [47:0] div_den;

	logic signed [31:0] g_q;
	logic               rs_q, pass_q;
	word_t dt2_q, khb_q, kb_q, omega_q, damp_q, recip_q, den_q;
	word_t t1_q, t2_q, num_q, a1_q, sv_q, v1_q, x1_q;
	word_t disp_q, vel_q, acc_q;
	logic [30:0] peak_q;
	logic [31:0] psq_q;
	logic [63:0] hc_q;

	word_t       hb, bq, den_n, xg, s_ab;
	logic        den_pos;
	logic signed [31:0] gsel, ab;
	logic [47:0] sm;
	logic [48:0] smr;
	logic [40:0] m_ab;
	logic [30:0] pk, peak_n;
	logic        slot_free;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= 16'd1000;
			step_q <= 10'd10;
			ratio_q <= 16'd3277;
			beta_q <= 16'd16384;
			sdisp_q <= '0;
			svel_q <= '0;
			sacc_q <= '0;
			sground_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PERIOD: period_q <= cfg_data[15:0];
				CFG_STEP:   step_q <= cfg_data[9:0];
				CFG_DAMP:   ratio_q <= cfg_data[15:0];
				CFG_BETA:   beta_q <= cfg_data[15:0];
				CFG_DISP:   sdisp_q <= cfg_data;
				CFG_VEL:    svel_q <= cfg_data;
				CFG_ACC:    sacc_q <= cfg_data;
				CFG_GROUND: sground_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Time step and half step follow step_ms through two register stages.
	assign dtp = 37'(dty_s1) * 37'(DT_RECIP);
	assign hfp = 42'(hfy_s1) * 42'(HF_RECIP);

	always_ff @(posedge clk) begin
		dty_s1 <= 18'(18'(step_q) * 18'(DT_REM)) + 18'(DT_RND);
		dtb_s1 <= 25'(step_q) * 25'(DT_INT);
		hfy_s1 <= 21'(21'(step_q) * 21'(HF_REM)) + 21'(HF_RND);
		hfb_s1 <= 24'(step_q) * 24'(HF_INT);
		dt_q <= word_t'(48'(dtb_s1) + 48'(dtp[36:28]));
		half_q <= word_t'(48'(hfb_s1) + 48'(hfp[41:31]));
	end

	nbsdof_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .q(mul_q), .prod(mul_prod)
	);

	nbsdof_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .q(div_q)
	);

	always_comb begin
		bq = word_t'({beta_q, 8'd0});
		hb = HALF_Q - bq;
		gsel = pass_q ? sground_q : g_q;
		xg = {{8{gsel[31]}}, gsel, 8'd0};
		den_n = sat_add(den_q, mul_q);
		den_pos = !den_n[47] && (den_n != '0);

		// Absolute acceleration back to 16 fraction bits, rounded away from zero.
		s_ab = sat_add(a1_q, xg);
		sm = s_ab[47] ? 48'(-s_ab) : 48'(s_ab);
		smr = 49'(sm) + 49'd128;
		m_ab = smr[48:8];
		if (s_ab[47]) begin
			ab = (m_ab >= 41'h080000000) ? 32'sh80000000 : -$signed(m_ab[31:0]);
		end else begin
			ab = (m_ab > 41'h07fffffff) ? 32'sh7fffffff : $signed(m_ab[31:0]);
		end
		pk = (m_ab > 41'h07fffffff) ? 31'h7fffffff : m_ab[30:0];
		peak_n = (pk > peak_q) ? pk : peak_q;
		slot_free = !out_valid || !out_stall;
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_DT2:  begin mul_a = dt_q; mul_b = dt_q; end
			S_KHB:  begin mul_a = hb; mul_b = dt2_q; end
			S_KB:   begin mul_a = bq; mul_b = dt2_q; end
			S_PSQ:  begin mul_a = word_t'(48'(period_q)); mul_b = word_t'(48'(period_q)); end
			S_HC:   begin mul_a = word_t'(48'(ratio_q)); mul_b = word_t'(DAMP_NUM); end
			S_DEN1: begin mul_a = half_q; mul_b = damp_q; end
			S_DEN2: begin mul_a = kb_q; mul_b = omega_q; end
			S_M1:   begin mul_a = half_q; mul_b = acc_q; end
			S_M2:   begin mul_a = dt_q; mul_b = vel_q; end
			S_M3:   begin mul_a = khb_q; mul_b = acc_q; end
			S_M4:   begin mul_a = damp_q; mul_b = t1_q; end
			S_M5:   begin mul_a = omega_q; mul_b = t2_q; end
			S_M6:   begin mul_a = num_q; mul_b = recip_q; end
			S_M7:   begin mul_a = sv_q; mul_b = half_q; end
			S_M8:   begin mul_a = kb_q; mul_b = a1_q; end
			default: ;
		endcase
		div_num = '0;
		div_den = '0;
		case (state_q)
			S_WDIV: begin
				div_num = 65'(OMEGA_NUM) + 65'({psq_q, 7'd0});
				div_den = 48'({psq_q, 8'd0});
			end
			S_DDIV: begin
				div_num = 65'(hc_q) + 65'({period_q, 23'd0});
				div_den = 48'({period_q, 24'd0});
			end
			S_RDIV: begin
				div_num = (65'd1 << (2 * FRAC_BITS)) + 65'(den_q[47:1]);
				div_den = den_q;
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issued_q <= 1'b0;
		end else begin
			state_q <= state_d;
			issued_q <= (is_mul || is_div) && !mul_done && !div_done;
		end
	end

	always_comb begin
		is_mul = state_q inside {S_DT2, S_KHB, S_KB, S_PSQ, S_HC, S_DEN1, S_DEN2,
			S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8};
		is_div = state_q inside {S_WDIV, S_DDIV, S_RDIV};
		mul_start = is_mul && !issued_q;
		div_start = is_div && !issued_q;
		in_stall = (state_q != S_IDLE);
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_PREP;
			S_PREP: state_d = S_DT2;
			S_DT2:  if (mul_done) state_d = S_KHB;
			S_KHB:  if (mul_done) state_d = S_KB;
			S_KB:   if (mul_done) state_d = rs_q ? S_PSQ : S_M1;
			S_PSQ:  if (mul_done) state_d = (period_q == '0) ? S_DEN1 : S_WDIV;
			S_WDIV: if (div_done) state_d = S_HC;
			S_HC:   if (mul_done) state_d = S_DDIV;
			S_DDIV: if (div_done) state_d = S_DEN1;
			S_DEN1: if (mul_done) state_d = S_DEN2;
			S_DEN2: if (mul_done) state_d = den_pos ? S_RDIV : S_LOAD;
			S_RDIV: if (div_done) state_d = S_LOAD;
			S_LOAD: state_d = S_M1;
			S_M1:   if (mul_done) state_d = S_M2;
			S_M2:   if (mul_done) state_d = S_M3;
			S_M3:   if (mul_done) state_d = S_M4;
			S_M4:   if (mul_done) state_d = S_M5;
			S_M5:   if (mul_done) state_d = S_M6;
			S_M6:   if (mul_done) state_d = S_M7;
			S_M7:   if (mul_done) state_d = S_M8;
			S_M8:   if (mul_done) state_d = S_FIN;
			S_FIN:  if (slot_free) state_d = pass_q ? S_M1 : S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Oscillator state and coefficients.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_q <= '0;
			vel_q <= '0;
			acc_q <= '0;
			peak_q <= '0;
			omega_q <= '0;
			damp_q <= '0;
			recip_q <= '0;
			rs_q <= 1'b0;
			pass_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) rs_q <= record_start;
				S_PREP: pass_q <= 1'b0;
				S_PSQ: begin
					if (mul_done && period_q == '0) begin
						omega_q <= WMAX;
						damp_q <= WMAX;
					end
				end
				S_WDIV: if (div_done) omega_q <= div_q;
				S_DDIV: if (div_done) damp_q <= div_q;
				S_DEN2: if (mul_done && !den_pos) recip_q <= '0;
				S_RDIV: if (div_done) recip_q <= div_q;
				S_LOAD: begin
					disp_q <= {{8{sdisp_q[31]}}, sdisp_q, 8'd0};
					vel_q <= {{8{svel_q[31]}}, svel_q, 8'd0};
					acc_q <= {{8{sacc_q[31]}}, sacc_q, 8'd0};
					peak_q <= '0;
					pass_q <= 1'b1;
				end
				S_FIN: begin
					if (slot_free) begin
						disp_q <= x1_q;
						vel_q <= v1_q;
						acc_q <= a1_q;
						peak_q <= peak_n;
						pass_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) g_q <= ground_acc;
		if (mul_done) begin
			case (state_q)
				S_DT2:  dt2_q <= mul_q;
				S_KHB:  khb_q <= mul_q;
				S_KB:   kb_q <= mul_q;
				S_PSQ:  psq_q <= mul_prod[31:0];
				S_HC:   hc_q <= mul_prod[63:0];
				S_DEN1: den_q <= sat_add(ONE_Q, mul_q);
				S_DEN2: den_q <= den_n;
				S_M1:   t1_q <= sat_add(vel_q, mul_q);
				S_M2:   t2_q <= sat_add(disp_q, mul_q);
				S_M3:   t2_q <= sat_add(t2_q, mul_q);
				S_M4:   num_q <= sat_sub(-xg, mul_q);
				S_M5:   num_q <= sat_sub(num_q, mul_q);
				S_M6: begin
					a1_q <= mul_q;
					sv_q <= sat_add(mul_q, acc_q);
				end
				S_M7:   v1_q <= sat_add(vel_q, mul_q);
				S_M8:   x1_q <= sat_add(t2_q, mul_q);
				default: ;
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == S_FIN && slot_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && slot_free) begin
			displacement <= x1_q;
			velocity <= v1_q;
			relative_acc <= a1_q;
			absolute_acc <= ab;
			peak_abs_acc <= peak_n;
			last_of_run <= !pass_q;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_PREP))
		else $error("accepted request did not start the sequence");

	a_first_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_of_run) |-> rs_q)
		else $error("non-final result without record start");

	a_mul_done_issued: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_done || div_done) |-> (issued_q && (is_mul || is_div)))
		else $error("arithmetic unit finished without a pending operation");

endmodule
